/* rtl/core/pol_pkg.sv */
package pol_pkg;

  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_READ_ALL  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } cell_cmd_t;

endpackage

/* rtl/core/pol_cell.sv */
module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic signed [VAL_W-1:0] head_value,
  output logic signed [VAL_W-1:0] value
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NextIdx = CNT_W'(IDX + 1);

  logic signed [VAL_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.op)
      CELL_INS: begin
        if (MyIdx > cmd.idx) begin
          value_next = left_value;
        end else if (MyIdx == cmd.idx) begin
          value_next = new_value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= cmd.idx) begin
          value_next = right_value;
        end
      end
      CELL_ROT: begin
        // The occupied part of the chain turns by one; the last occupied
        // cell picks up the old front entry.
        if (NextIdx < cmd.cnt) begin
          value_next = right_value;
        end else if (NextIdx == cmd.cnt) begin
          value_next = head_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* rtl/core/positional_ordered_list.sv */
// An edit request's or empty read_all's result is registered at its accepting
// edge and valid in the next cycle; a non-empty read_all first enters the read
// state and holds the request port until its last result is registered, as the
// chain of cells rotates one step per result and the front cell feeds the output.
// Requests are taken whenever the response slot is free and no read is under
// way. Reset: synchronous; clears the entry count and all handshake state.
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [2:0]              req_type,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic [POS_W-1:0]        position,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] out_value,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    last_result
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        rem;
  logic                    slot_free;
  logic                    req_fire;
  logic                    step;
  logic                    start_read;
  status_t                 st_next;
  cell_cmd_t               cmd;
  logic                    full;
  logic [POS_W:0]          pos_ext;
  logic [POS_W:0]          cnt_ext;
  logic signed [VAL_W-1:0] cells [CAPACITY];

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign req_fire  = req_valid && req_ready;
  assign step      = (state == S_READ) && slot_free;
  assign full      = cnt >= Cap;
  assign pos_ext   = {1'b0, position};
  assign cnt_ext   = {{(POS_W + 1 - CNT_W){1'b0}}, cnt};

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.idx    = '0;
    cmd.cnt    = cnt;
    st_next    = ST_OK;
    cnt_next   = cnt;
    start_read = 1'b0;
    if (req_fire) begin
      case (req_type)
        REQ_INS_FRONT, REQ_INS_BACK: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            cmd.op   = CELL_INS;
            cmd.idx  = (req_type == REQ_INS_FRONT) ? '0 : cnt;
            cnt_next = cnt + 1'b1;
          end
        end
        REQ_INS_AT: begin
          if (position == '0 || pos_ext > cnt_ext + 1'b1) begin
            st_next = ST_BADPOS;
          end else if (full) begin
            st_next = ST_FULL;
          end else begin
            cmd.op   = CELL_INS;
            cmd.idx  = CNT_W'(position - 1'b1);
            cnt_next = cnt + 1'b1;
          end
        end
        REQ_DEL_FRONT, REQ_DEL_BACK: begin
          if (cnt == '0) begin
            st_next = ST_EMPTY;
          end else begin
            cmd.op   = CELL_DEL;
            cmd.idx  = (req_type == REQ_DEL_FRONT) ? '0 : cnt - 1'b1;
            cnt_next = cnt - 1'b1;
          end
        end
        REQ_DEL_AT: begin
          if (position == '0 || pos_ext > cnt_ext) begin
            st_next = ST_BADPOS;
          end else begin
            cmd.op   = CELL_DEL;
            cmd.idx  = CNT_W'(position - 1'b1);
            cnt_next = cnt - 1'b1;
          end
        end
        REQ_READ_ALL: begin
          if (cnt == '0) begin
            st_next = ST_EMPTY;
          end else begin
            start_read = 1'b1;
          end
        end
        default: begin
          st_next = ST_OK;
        end
      endcase
    end else if (step) begin
      cmd.op = CELL_ROT;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = item_value;
    end else begin : g_mid_l
      assign left_value = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_value = cells[g];
    end else begin : g_mid_r
      assign right_value = cells[g+1];
    end

    pol_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_value  (item_value),
      .left_value (left_value),
      .right_value(right_value),
      .head_value (cells[0]),
      .value      (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rem       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((req_fire && !start_read) || step) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_fire) begin
        cnt <= cnt_next;
        if (start_read) begin
          state <= S_READ;
          rem   <= cnt;
        end else begin
          status      <= st_next;
          out_value   <= '0;
          entry_count <= cnt_next;
          last_result <= 1'b1;
        end
      end
      if (step) begin
        status      <= ST_OK;
        out_value   <= cells[0];
        entry_count <= cnt;
        last_result <= (rem == CNT_W'(1));
        rem         <= rem - 1'b1;
        if (rem == CNT_W'(1)) begin
          state <= S_IDLE;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= Cap))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (cnt == $past(cnt)))
    else $error("entry count changed during read out");

  assert property (@(posedge clk) disable iff (rst)
    (req_fire && st_next != ST_OK) |=> (cnt == $past(cnt)))
    else $error("failed request changed the entry count");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !last_result) |-> (status == ST_OK && state == S_READ))
    else $error("non-final result outside read out");

endmodule

/* test/positional_ordered_list_test.sv */
`timescale 1ns / 100ps

module positional_ordered_list_test
  import pol_pkg::*;
;

  localparam int CAP = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } list_req_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } list_rsp_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_ready;
  logic [2:0]              req_type = REQ_INS_FRONT;
  logic signed [VAL_W-1:0] item_value = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    rsp_valid;
  logic                    rsp_ready = 1'b0;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0]        entry_count;
  logic                    last_result;

  list_req_t pending_reqs[$];
  list_rsp_t awaited_rsps[$];

  // Shadow copy of the list contents, front at index 0.
  logic signed [VAL_W-1:0] list_vals[CAP];
  int list_len = 0;

  int  gen_len = 0;
  int  total_reqs = 0;
  int  req_done = 0;
  int  error_count = 0;
  int  cycle_n = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic req_taken = 1'b0;
  logic steady;

  assign steady = (req_done >= 90) && (req_done < 120);

  positional_ordered_list #(CAP) dut (
    clk, rst, req_valid, req_ready, req_type, item_value, position,
    rsp_valid, rsp_ready, status, out_value, entry_count, last_result
  );

  always #5 clk = ~clk;

  function automatic void list_insert(int idx, logic signed [VAL_W-1:0] value);
    for (int i = list_len; i > idx; i--) begin
      list_vals[i] = list_vals[i-1];
    end
    list_vals[idx] = value;
    list_len++;
  endfunction

  function automatic void list_remove(int idx);
    for (int i = idx; i + 1 < list_len; i++) begin
      list_vals[i] = list_vals[i+1];
    end
    list_len--;
  endfunction

  function automatic void push_rsp(status_t st, logic signed [VAL_W-1:0] value, logic last);
    list_rsp_t r;
    r.status = st;
    r.value = value;
    r.count = CNT_W'(list_len);
    r.last = last;
    awaited_rsps.push_back(r);
  endfunction

  // Applies one accepted request to the shadow list and queues its responses.
  function automatic void predict_list_op(list_req_t rq);
    status_t st;
    int p;
    st = ST_OK;
    p = int'(rq.pos);
    case (rq.kind)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (list_len >= CAP) st = ST_FULL;
        else list_insert(rq.kind == REQ_INS_FRONT ? 0 : list_len, rq.value);
      end
      REQ_INS_AT: begin
        if (p == 0 || p > list_len + 1) st = ST_BADPOS;
        else if (list_len >= CAP) st = ST_FULL;
        else list_insert(p - 1, rq.value);
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_remove(rq.kind == REQ_DEL_FRONT ? 0 : list_len - 1);
      end
      REQ_DEL_AT: begin
        if (p == 0 || p > list_len) st = ST_BADPOS;
        else list_remove(p - 1);
      end
      REQ_READ_ALL: begin
        if (list_len == 0) st = ST_EMPTY;
      end
      default: ;
    endcase
    if (rq.kind == REQ_READ_ALL && list_len != 0) begin
      for (int i = 0; i < list_len; i++) begin
        push_rsp(ST_OK, list_vals[i], i + 1 == list_len);
      end
    end else begin
      push_rsp(st, '0, 1'b1);
    end
  endfunction

  function automatic void queue_request(logic [2:0] kind, logic signed [VAL_W-1:0] value,
                                        logic [POS_W-1:0] pos);
    list_req_t rq;
    rq.kind = kind;
    rq.value = value;
    rq.pos = pos;
    pending_reqs.push_back(rq);
    total_reqs++;
  endfunction

  // Random request biased by phase; gen_len roughly follows the list length
  // so that most positions land inside the list.
  function automatic void queue_random(int ins_pct, int del_pct);
    int r;
    logic [2:0] kind;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      case ($urandom_range(0, 2))
        0: kind = REQ_INS_FRONT;
        1: kind = REQ_INS_BACK;
        default: kind = REQ_INS_AT;
      endcase
    end else if (r < ins_pct + del_pct) begin
      case ($urandom_range(0, 2))
        0: kind = REQ_DEL_FRONT;
        1: kind = REQ_DEL_BACK;
        default: kind = REQ_DEL_AT;
      endcase
    end else if (r < 97) begin
      kind = REQ_READ_ALL;
    end else begin
      kind = REQ_UNUSED;
    end
    if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom_range(0, 255));
    else if (kind == REQ_DEL_AT) pos = POS_W'($urandom_range(1, gen_len > 0 ? gen_len : 1));
    else pos = POS_W'($urandom_range(1, gen_len + 1));
    case (kind)
      REQ_INS_FRONT, REQ_INS_BACK: if (gen_len < CAP) gen_len++;
      REQ_INS_AT: if (pos != 0 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
      REQ_DEL_FRONT, REQ_DEL_BACK: if (gen_len > 0) gen_len--;
      REQ_DEL_AT: if (pos != 0 && pos <= gen_len) gen_len--;
      default: ;
    endcase
    queue_request(kind, $urandom, pos);
  endfunction

  // Request driver.
  always @(negedge clk) begin : drive_req
    list_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
        nxt = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_type <= nxt.kind;
        item_value <= nxt.value;
        position <= nxt.pos;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls plus one long hold-off so that the block
  // backs up and stalls its request port.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_done >= 40) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  // Monitor: predict on each accepted request, check each accepted response.
  always @(posedge clk) begin : watch
    list_req_t rq;
    list_rsp_t exp_rsp;
    req_taken <= !rst && req_valid && req_ready;
    if (!rst && req_valid && req_ready) begin
      rq.kind = req_type;
      rq.value = item_value;
      rq.pos = position;
      predict_list_op(rq);
      req_done <= req_done + 1;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsps.size() == 0) begin
        $error("response with nothing expected: status %0d value %0d count %0d last %0b",
               status, out_value, entry_count, last_result);
        error_count++;
      end else begin
        exp_rsp = awaited_rsps.pop_front();
        if (status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, status);
          error_count++;
        end
        if (out_value !== exp_rsp.value) begin
          $error("out_value: expected %0d, got %0d", exp_rsp.value, out_value);
          error_count++;
        end
        if (entry_count !== exp_rsp.count) begin
          $error("entry_count: expected %0d, got %0d", exp_rsp.count, entry_count);
          error_count++;
        end
        if (last_result !== exp_rsp.last) begin
          $error("last_result: expected %0b, got %0b", exp_rsp.last, last_result);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Directed corner cases first, starting on the empty list.
    queue_request(REQ_READ_ALL, '0, '0);
    queue_request(REQ_DEL_FRONT, '0, '0);
    queue_request(REQ_DEL_BACK, '0, '0);
    queue_request(REQ_DEL_AT, '0, 8'd1);
    queue_request(REQ_INS_AT, 32'sd5, 8'd0);
    queue_request(REQ_INS_AT, 32'sd6, 8'd2);
    queue_request(REQ_INS_AT, 32'sh7fffffff, 8'd1);
    queue_request(REQ_INS_FRONT, 32'sh80000000, '0);
    queue_request(REQ_INS_BACK, -32'sd1, 8'd255);
    queue_request(REQ_INS_AT, 32'sd7, 8'd255);
    queue_request(REQ_INS_AT, 32'sd0, 8'd4);
    queue_request(REQ_INS_AT, 32'sh5a5a5a5a, 8'd2);
    queue_request(REQ_READ_ALL, '0, '0);
    queue_request(REQ_UNUSED, -32'sd1, 8'd255);
    queue_request(REQ_DEL_AT, '0, 8'd0);
    queue_request(REQ_DEL_AT, '0, 8'd6);
    queue_request(REQ_DEL_AT, '0, 8'd5);
    queue_request(REQ_DEL_AT, '0, 8'd2);
    queue_request(REQ_DEL_FRONT, '0, '0);
    queue_request(REQ_DEL_BACK, '0, '0);
    queue_request(REQ_READ_ALL, '0, '0);
    queue_request(REQ_DEL_AT, '0, 8'd1);
    queue_request(REQ_READ_ALL, '0, '0);
    gen_len = 0;

    // Fill past capacity, drain past empty, then mix.
    repeat (45) queue_random(80, 8);
    repeat (40) queue_random(10, 78);
    repeat (45) queue_random(42, 40);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_done < total_reqs || awaited_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
